// File: hw/rtl/bdq_pkg.sv
package bdq_pkg;

   // field widths
   localparam int MODE_W  = 3;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 7;

   // stream widths, padded to whole bytes
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 72;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // value reported for either end of an empty deque
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming item
      logic execute;   // apply the operation to the ring
      logic read;      // fetch front and rear entries
   } ctl_type;

endpackage

// File: hw/rtl/bdq_ctrl.sv
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output bdq_pkg::ctl_type  ctl
);
   import bdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_READ;
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      ctl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            ctl.capture = req_tvalid;
         end
         ST_EXEC: ctl.execute = 1'b1;
         ST_READ: ctl.read    = 1'b1;
         ST_RESP: rsp_tvalid  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/bdq_datapath.sv
module bdq_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bdq_pkg::ctl_type                    ctl,
   input  logic                                csr_wr_en,
   input  logic [bdq_pkg::CAP_W-1:0]           csr_wr_data,
   input  logic [bdq_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [bdq_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_ok,
   output logic signed [bdq_pkg::DATA_W-1:0]   rsp_front,
   output logic signed [bdq_pkg::DATA_W-1:0]   rsp_rear,
   output logic                                rsp_empty,
   output logic                                rsp_full
);
   import bdq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // ring index
   localparam int CW = $clog2(DEPTH + 1);                 // entry count
   localparam int SW = CW + 1;                            // index sums
   localparam int KW = (CW > CAP_W) ? CW : CAP_W;         // capacity compare

   logic [CAP_W-1:0]         cap_ff;
   logic [MODE_W-1:0]        mode_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     ok_ff, ok_in;
   logic signed [DATA_W-1:0] rd_front_ff, rd_rear_ff;
   logic signed [DATA_W-1:0] mem [DEPTH];

   logic [KW-1:0]  cap_ext, cap_eff;
   logic           full, empty;
   logic [AW-1:0]  head_dec, head_inc, tail_addr, rear_addr, wr_addr;
   logic [SW-1:0]  inc_sum, tail_sum, rear_sum;
   logic           wr_en;

   // effective capacity, saturated to 1..DEPTH
   always_comb begin
      cap_ext = KW'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = KW'(1);
      end else if (cap_ext > KW'(DEPTH)) begin
         cap_eff = KW'(DEPTH);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign full  = (KW'(count_ff) >= cap_eff);
   assign empty = (count_ff == '0);

   // ring index arithmetic, one wrap correction each
   always_comb begin
      head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
      inc_sum  = SW'(head_ff) + SW'(1);
      head_inc = (inc_sum >= SW'(DEPTH)) ? AW'(inc_sum - SW'(DEPTH)) : AW'(inc_sum);
      tail_sum = SW'(head_ff) + SW'(count_ff);
      tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
      rear_sum = tail_sum - SW'(1);
      rear_addr = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);
   end

   // operation decode
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_addr;
      if (ctl.execute) begin
         ok_in = 1'b0;
         unique case (mode_ff)
            MODE_PUSH_FRONT: begin
               if (!full) begin
                  head_in  = head_dec;
                  wr_addr  = head_dec;
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  ok_in    = 1'b1;
               end
            end
            MODE_PUSH_REAR: begin
               if (!full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  ok_in    = 1'b1;
               end
            end
            MODE_POP_FRONT: begin
               if (!empty) begin
                  head_in  = head_inc;
                  count_in = count_ff - CW'(1);
                  ok_in    = 1'b1;
               end
            end
            MODE_POP_REAR: begin
               if (!empty) begin
                  count_in = count_ff - CW'(1);
                  ok_in    = 1'b1;
               end
            end
            MODE_PEEK: ok_in = 1'b1;
            default:   ok_in = 1'b0;   // unused codes: no operation
         endcase
      end
   end

   // control state and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         count_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         head_ff  <= head_in;
         count_ff <= count_in;
         ok_ff    <= ok_in;
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
   end

   // entry memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (ctl.read) begin
         rd_front_ff <= mem[head_ff];
         rd_rear_ff  <= mem[rear_addr];
      end
   end

   // result fields
   assign rsp_ok    = ok_ff;
   assign rsp_empty = empty;
   assign rsp_full  = full;
   assign rsp_front = empty ? EMPTY_VALUE : rd_front_ff;
   assign rsp_rear  = empty ? EMPTY_VALUE : rd_rear_ff;

endmodule

// File: hw/rtl/bounded_deque_core.sv
// Sequence: an accepted item steps through the execute state (memory write),
//   the read state (registered front/rear read) and the respond state, in which
//   the result is valid. Flow: one item in flight; the next is accepted
//   the cycle after the result is taken.
// Reset: synchronous, clears head index, entry count and controller state and
//   sets capacity to 64; entry memory is not cleared.
module bounded_deque_core #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bdq_pkg::REQ_W-1:0]     req_tdata,   // mode[2:0], value[34:3], zero pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bdq_pkg::RSP_W-1:0]     rsp_tdata,   // ok[0], front_value[32:1],
                                                      // rear_value[64:33], is_empty[65],
                                                      // is_full[66], zero pad
   input  logic                          csr_wr_en,
   input  logic [bdq_pkg::CAP_W-1:0]     csr_wr_data
);
   import bdq_pkg::*;

   ctl_type                  ctl;
   logic                     rsp_ok, rsp_empty, rsp_full;
   logic signed [DATA_W-1:0] rsp_front, rsp_rear;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mode    (req_tdata[MODE_W-1:0]),
      .req_value   (req_tdata[MODE_W+DATA_W-1:MODE_W]),
      .rsp_ok      (rsp_ok),
      .rsp_front   (rsp_front),
      .rsp_rear    (rsp_rear),
      .rsp_empty   (rsp_empty),
      .rsp_full    (rsp_full)
   );

   // pack the result item
   assign rsp_tdata = {(RSP_W - 2*DATA_W - 3)'(0), rsp_full, rsp_empty,
                       rsp_rear, rsp_front, rsp_ok};

   // one item at a time: never accepting while a result is shown
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("item accepted while result pending");

   // fixed latency from accept to result
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##3 rsp_tvalid)
      else $error("result not valid three cycles after accept");

   // empty deque reports -1 at both ends and is never full
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_empty) |->
         (rsp_front == EMPTY_VALUE && rsp_rear == EMPTY_VALUE && !rsp_full))
      else $error("empty result inconsistent");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
   import bdq_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 200;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] value;
   } deque_op_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front;
      logic signed [DATA_W-1:0] rear;
      logic                     empty;
      logic                     full;
   } deque_view_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;   // mode[2:0], value[34:3], zero pad
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;   // ok[0], front_value[32:1], rear_value[64:33],
                                      // is_empty[65], is_full[66], zero pad
   logic                 csr_wr_en;
   logic [CAP_W-1:0]     csr_wr_data;

   bounded_deque_core #(.DEPTH(RING_DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the deque
   logic signed [DATA_W-1:0] ring [RING_DEPTH];
   logic [5:0]               ring_head;
   logic [6:0]               ring_count;
   logic [CAP_W-1:0]         cap_reg;

   deque_op_type   ops_to_send [$];
   deque_view_type views_due [$];
   deque_op_type   next_op;

   // handshake bookkeeping; set at the rising edge, consumed at the falling edge
   bit          req_taken;
   int unsigned send_wait;
   int unsigned recv_wait;
   int unsigned hold_left;
   bit          hold_armed;
   int          send_style;
   int          recv_style;

   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned n_results;
   int unsigned n_refused;
   int unsigned n_full_seen;
   int unsigned n_empty_seen;
   int unsigned n_cap_writes;

   // style 0: back to back, 1: uniform random gaps, 2: mostly back to back
   function automatic int unsigned draw_wait(int style);
      case (style)
         0:       return 0;
         1:       return $urandom_range(0, 10);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   // apply one operation to the shadow deque and return the state it reports
   function automatic deque_view_type deque_apply(logic [MODE_W-1:0] mode,
                                                  logic [DATA_W-1:0] value);
      deque_view_type v;
      logic [6:0]  eff_cap;
      logic [5:0]  slot;
      logic        was_full;
      logic        was_empty;
      if (cap_reg == 0)
         eff_cap = 7'd1;
      else if (cap_reg > RING_DEPTH)
         eff_cap = 7'(RING_DEPTH);
      else
         eff_cap = cap_reg;
      was_full  = ring_count >= eff_cap;
      was_empty = ring_count == 0;
      v.ok = 1'b0;
      case (mode)
         MODE_PUSH_FRONT: if (!was_full) begin
            ring_head = ring_head - 6'd1;
            ring[ring_head] = value;
            ring_count++;
            v.ok = 1'b1;
         end
         MODE_PUSH_REAR: if (!was_full) begin
            slot = ring_head + ring_count[5:0];
            ring[slot] = value;
            ring_count++;
            v.ok = 1'b1;
         end
         MODE_POP_FRONT: if (!was_empty) begin
            ring_head = ring_head + 6'd1;
            ring_count--;
            v.ok = 1'b1;
         end
         MODE_POP_REAR: if (!was_empty) begin
            ring_count--;
            v.ok = 1'b1;
         end
         MODE_PEEK: v.ok = 1'b1;
         default: ;
      endcase
      v.empty = ring_count == 0;
      v.full  = ring_count >= eff_cap;
      if (v.empty) begin
         v.front = EMPTY_VALUE;
         v.rear  = EMPTY_VALUE;
      end else begin
         // count of 64 wraps to head - 1, which is the right rear slot
         slot = ring_head + ring_count[5:0] - 6'd1;
         v.front = ring[ring_head];
         v.rear  = ring[slot];
      end
      return v;
   endfunction

   task automatic queue_op(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
      deque_op_type op;
      op.mode  = mode;
      op.value = value;
      ops_to_send.push_back(op);
   endtask

   // wait until every item is sent and answered, then let the block settle
   task automatic wait_drained();
      while (ops_to_send.size() > 0 || req_tvalid || views_due.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cap_reg = cap;
      n_cap_writes++;
   endtask

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // item sender: holds each item until taken, then waits its drawn gap
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (ops_to_send.size() > 0) begin
               next_op = ops_to_send.pop_front();
               req_tdata  <= {5'b0, next_op.value, next_op.mode};
               req_tvalid <= 1'b1;
               send_wait = draw_wait(send_style);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result receiver: per-item stall, plus one long hold-off on request
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // check results, then predict for newly accepted items
   always @(posedge clock) begin
      deque_view_type got;
      deque_view_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.ok    = rsp_tdata[0];
            got.front = rsp_tdata[32:1];
            got.rear  = rsp_tdata[64:33];
            got.empty = rsp_tdata[65];
            got.full  = rsp_tdata[66];
            recv_wait = draw_wait(recv_style);
            if (views_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                        $time, got.ok, got.front, got.rear, got.empty, got.full);
            end else begin
               want = views_due.pop_front();
               n_results++;
               if (!want.ok) n_refused++;
               if (want.full) n_full_seen++;
               if (want.empty) n_empty_seen++;
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: result %0d mismatch", $time, n_results);
                  $display("   expected ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                           want.ok, want.front, want.rear, want.empty, want.full);
                  $display("   actual   ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                           got.ok, got.front, got.rear, got.empty, got.full);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            views_due.push_back(deque_apply(req_tdata[2:0], req_tdata[34:3]));
            req_taken = 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned phase_cap  [12];
      int unsigned phase_push [12];
      int unsigned r;
      logic [MODE_W-1:0] mode;
      phase_cap  = '{64, 64, 1, 127, 127, 3, 0, 65, 16, 2, 40, 64};
      phase_push = '{80, 15, 50, 85, 20, 50, 50, 70, 45, 40, 75, 10};

      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      ring_head   = '0;
      ring_count  = '0;
      cap_reg     = CAP_RESET;
      send_style  = 0;
      recv_style  = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty deque at reset capacity: refused pops, peeks, unused modes, extremes
      queue_op(MODE_POP_FRONT, 32'h0);
      queue_op(MODE_POP_REAR, 32'h0);
      queue_op(MODE_PEEK, 32'h0);
      queue_op(3'd5, 32'hA5A5_A5A5);
      queue_op(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
      queue_op(MODE_PUSH_REAR, 32'h8000_0000);
      queue_op(3'd6, 32'h0);
      queue_op(MODE_POP_FRONT, 32'hFFFF_FFFF);
      queue_op(MODE_PEEK, 32'h5A5A_5A5A);
      queue_op(MODE_POP_REAR, 32'h0);
      queue_op(3'd7, 32'hFFFF_FFFF);
      queue_op(MODE_PUSH_REAR, 32'hFFFF_FFFF);
      wait_drained();

      // capacity 0 behaves as 1; deque already holds one entry
      write_capacity(7'd0);
      queue_op(MODE_PUSH_FRONT, 32'h5);
      queue_op(MODE_POP_REAR, 32'h0);
      queue_op(MODE_PUSH_FRONT, 32'h1234_5678);
      queue_op(MODE_PUSH_REAR, 32'h9);
      queue_op(MODE_POP_FRONT, 32'h0);
      wait_drained();

      // fill four, then lower capacity below the count
      write_capacity(7'd8);
      queue_op(MODE_PUSH_REAR, 32'h1111_1111);
      queue_op(MODE_PUSH_FRONT, 32'h2222_2222);
      queue_op(MODE_PUSH_REAR, 32'hDEAD_BEEF);
      queue_op(MODE_PUSH_FRONT, 32'h8000_0001);
      wait_drained();
      write_capacity(7'd2);
      queue_op(MODE_PUSH_REAR, 32'h3);
      queue_op(MODE_POP_FRONT, 32'h0);
      queue_op(MODE_POP_REAR, 32'h0);
      queue_op(MODE_POP_FRONT, 32'h0);
      queue_op(MODE_PUSH_REAR, 32'h7);
      wait_drained();

      // random phases: capacity and push bias vary, contents carry over
      for (int p = 0; p < 12; p++) begin
         write_capacity(CAP_W'(phase_cap[p]));
         send_style = p % 3;
         recv_style = (p + 1) % 3;
         if (p == 3) hold_armed = 1'b1;
         for (int i = 0; i < 100; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               mode = 3'($urandom_range(5, 7));
            else if (r < 8)
               mode = MODE_PEEK;
            else if (r < 8 + phase_push[p] * 92 / 100)
               mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
            else
               mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
            queue_op(mode, draw_value());
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("tb_top: %0d results checked, %0d refused, %0d reported full, %0d empty",
               n_results, n_refused, n_full_seen, n_empty_seen);
      $display("tb_top: %0d capacity writes incl. 0, 1, 64 and above 64; %0d mismatches",
               n_cap_writes, mismatch_count);
      if (mismatch_count == 0 && views_due.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
